// ===== src/tls_sni_extractor_defines.svh =====
// Assertion helpers for the SNI extractor RTL.
`ifndef TLS_SNI_EXTRACTOR_DEFINES_SVH
`define TLS_SNI_EXTRACTOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define TSE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tse assertion failed");
`define TSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tse assertion failed");
`else
`define TSE_ASSERT(lbl, clk, rst_n, prop)
`define TSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== src/tse_pkg.sv =====
package tse_pkg;

	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_NO_SNI = 2'd1;
	localparam logic [1:0] ST_SHORT  = 2'd2;

	typedef struct packed {
		logic       is_verdict;
		logic [7:0] name_byte;
		logic [7:0] name_index;
		logic [1:0] status;
		logic [7:0] name_length;
		logic       run_end;
	} res_t;

	// results produced by one parsed byte, res0 first
	typedef struct packed {
		logic [1:0] cnt;
		res_t       res0;
		res_t       res1;
	} push_t;

endpackage

// ===== src/tse_if.sv =====
interface tse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface tse_out_if;
	logic       valid;
	logic       ready;
	logic       is_verdict;
	logic [7:0] name_byte;
	logic [7:0] name_index;
	logic [1:0] status;
	logic [7:0] name_length;
	logic       run_end;

	modport source(output valid, output is_verdict, output name_byte, output name_index,
		output status, output name_length, output run_end, input ready);
	modport sink(input valid, input is_verdict, input name_byte, input name_index,
		input status, input name_length, input run_end, output ready);
endinterface

// ===== src/tse_res_fifo.sv =====
`include "tls_sni_extractor_defines.svh"

module tse_res_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  tse_pkg::push_t  push,
	output logic            space_ok,
	tse_out_if.source       res
);

	localparam int unsigned Depth = 8;
	localparam int unsigned PtrW  = $clog2(Depth);
	localparam int unsigned CntW  = $clog2(Depth + 1);

	tse_pkg::res_t mem_q [Depth];
	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] rp_q;
	logic [CntW-1:0] count_q;
	logic            pop;
	tse_pkg::res_t   head;

	assign pop      = res.valid && res.ready;
	// room for the byte now in the input register plus one more request
	assign space_ok = count_q <= CntW'(Depth - 4);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wp_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wp_q + PtrW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PtrW'(push.cnt);
			rp_q    <= rp_q + PtrW'(pop);
			count_q <= count_q + CntW'(push.cnt) - CntW'(pop);
		end
	end

	assign head             = mem_q[rp_q];
	assign res.valid        = count_q != '0;
	assign res.is_verdict   = head.is_verdict;
	assign res.name_byte    = head.name_byte;
	assign res.name_index   = head.name_index;
	assign res.status       = head.status;
	assign res.name_length  = head.name_length;
	assign res.run_end      = head.run_end;

	`TSE_ASSERT(a_push_room, clk, arst_n, (push.cnt != 2'd0) |-> (count_q <= CntW'(Depth - 2)))
	`TSE_ASSERT(a_count_bound, clk, arst_n, count_q <= CntW'(Depth))

endmodule

// ===== src/tse_parser.sv =====
`include "tls_sni_extractor_defines.svh"

module tse_parser #(
	parameter int MAX_NAME = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     in_data,
	input  logic           in_last,
	input  logic           cfg_wr_en,
	input  logic [8:0]     cfg_wr_data,
	output tse_pkg::push_t push
);

	localparam logic [3:0] PH_CTYPE      = 4'd0;
	localparam logic [3:0] PH_HEADER     = 4'd1;
	localparam logic [3:0] PH_SESS_LEN   = 4'd2;
	localparam logic [3:0] PH_SESS_SKIP  = 4'd3;
	localparam logic [3:0] PH_CIPH_HI    = 4'd4;
	localparam logic [3:0] PH_CIPH_LO    = 4'd5;
	localparam logic [3:0] PH_CIPH_SKIP  = 4'd6;
	localparam logic [3:0] PH_COMP_LEN   = 4'd7;
	localparam logic [3:0] PH_COMP_SKIP  = 4'd8;
	localparam logic [3:0] PH_EXT_TOT_HI = 4'd9;
	localparam logic [3:0] PH_EXT_TOT_LO = 4'd10;
	localparam logic [3:0] PH_EXT_HDR    = 4'd11;
	localparam logic [3:0] PH_EXT_SKIP   = 4'd12;
	localparam logic [3:0] PH_SNI_PREFIX = 4'd13;
	localparam logic [3:0] PH_SNI_NAME   = 4'd14;
	localparam logic [3:0] PH_DONE       = 4'd15;

	localparam logic [8:0]  MaxCap = 9'(MAX_NAME);
	localparam logic [16:0] PosMax = '1;

	localparam logic [7:0] CtypeHandshake = 8'h16;
	localparam logic [7:0] HsClientHello  = 8'h01;
	localparam logic [15:0] ExtServerName = 16'h0000;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	logic [8:0]  cap_q;
	logic [16:0] pos_q;
	logic [3:0]  phase_q;
	logic [15:0] skip_q;
	logic [15:0] rlen_q;
	logic [16:0] ee_q;
	logic [15:0] etype_q;
	logic [7:0]  hold_q;
	logic [7:0]  target_q;
	logic [7:0]  nemit_q;
	logic        done_q;

	logic [16:0] n_pos;
	logic [3:0]  n_phase;
	logic [15:0] n_skip;
	logic [15:0] n_rlen;
	logic [16:0] n_ee;
	logic [15:0] n_etype;
	logic [7:0]  n_hold;
	logic [7:0]  n_target;
	logic [7:0]  n_nemit;
	logic        n_done;

	logic [15:0] skip_dec;
	logic [16:0] ee_dec;
	logic [15:0] elen;
	logic [15:0] nl;
	logic [8:0]  cap_eff;
	logic [7:0]  lim;
	logic [16:0] ee_tot;
	logic [17:0] count;
	logic [17:0] rlen_need;
	logic        name_hit;
	tse_pkg::res_t name_res;
	tse_pkg::res_t verd_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= in_data;
		last_s1 <= in_last;
	end

	always_comb begin
		cap_eff = cap_q;
		if (cap_q < 9'd2) begin
			cap_eff = 9'd2;
		end else if (cap_q > MaxCap) begin
			cap_eff = MaxCap;
		end
	end

	assign lim       = 8'(cap_eff - 9'd1);
	assign skip_dec  = skip_q - 16'd1;
	assign ee_dec    = (ee_q != '0) ? ee_q - 17'd1 : ee_q;
	assign elen      = {hold_q, data_s1};
	assign nl        = elen - 16'd5;
	assign ee_tot    = {1'b0, hold_q, data_s1};
	assign count     = {1'b0, pos_q} + 18'd1;

	always_comb begin
		n_pos    = (pos_q != PosMax) ? pos_q + 17'd1 : pos_q;
		n_phase  = phase_q;
		n_skip   = skip_q;
		n_rlen   = rlen_q;
		n_ee     = ee_q;
		n_etype  = etype_q;
		n_hold   = hold_q;
		n_target = target_q;
		n_nemit  = nemit_q;
		n_done   = done_q;
		name_hit = 1'b0;

		case (phase_q)
			PH_CTYPE: begin
				n_phase = (data_s1 == CtypeHandshake) ? PH_HEADER : PH_DONE;
			end
			PH_HEADER: begin
				if (pos_q == 17'd3) begin
					n_rlen = {data_s1, 8'h00};
				end else if (pos_q == 17'd4) begin
					n_rlen = {rlen_q[15:8], data_s1};
				end
				if (pos_q == 17'd5 && data_s1 != HsClientHello) begin
					n_phase = PH_DONE;
				end else if (pos_q >= 17'd42) begin
					n_phase = PH_SESS_LEN;
				end
			end
			PH_SESS_LEN: begin
				n_skip  = {8'h00, data_s1};
				n_phase = (data_s1 == 8'h00) ? PH_CIPH_HI : PH_SESS_SKIP;
			end
			PH_SESS_SKIP: begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					n_phase = PH_CIPH_HI;
				end
			end
			PH_CIPH_HI: begin
				n_hold  = data_s1;
				n_phase = PH_CIPH_LO;
			end
			PH_CIPH_LO: begin
				n_skip  = elen;
				n_phase = (elen == '0) ? PH_COMP_LEN : PH_CIPH_SKIP;
			end
			PH_CIPH_SKIP: begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					n_phase = PH_COMP_LEN;
				end
			end
			PH_COMP_LEN: begin
				n_skip  = {8'h00, data_s1};
				n_phase = (data_s1 == 8'h00) ? PH_EXT_TOT_HI : PH_COMP_SKIP;
			end
			PH_COMP_SKIP: begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					n_phase = PH_EXT_TOT_HI;
				end
			end
			PH_EXT_TOT_HI: begin
				n_hold  = data_s1;
				n_phase = PH_EXT_TOT_LO;
			end
			PH_EXT_TOT_LO: begin
				n_ee = ee_tot;
				if (ee_tot >= 17'd4) begin
					n_phase = PH_EXT_HDR;
					n_skip  = '0;
				end else begin
					n_phase = PH_DONE;
				end
			end
			PH_EXT_HDR: begin
				n_ee = ee_dec;
				// skip_q counts header bytes: type hi, type lo, length hi, length lo
				if (skip_q == 16'd0) begin
					n_etype = {data_s1, 8'h00};
					n_skip  = 16'd1;
				end else if (skip_q == 16'd1) begin
					n_etype = {etype_q[15:8], data_s1};
					n_skip  = 16'd2;
				end else if (skip_q == 16'd2) begin
					n_hold = data_s1;
					n_skip = 16'd3;
				end else if (etype_q == ExtServerName && elen > 16'd5) begin
					n_target = (nl > {8'h00, lim}) ? lim : nl[7:0];
					n_skip   = 16'd5;
					n_phase  = PH_SNI_PREFIX;
				end else if (elen == '0) begin
					if (ee_dec >= 17'd4) begin
						n_phase = PH_EXT_HDR;
						n_skip  = '0;
					end else begin
						n_phase = PH_DONE;
					end
				end else begin
					n_skip  = elen;
					n_phase = PH_EXT_SKIP;
				end
			end
			PH_EXT_SKIP: begin
				n_ee   = ee_dec;
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					if (ee_dec >= 17'd4) begin
						n_phase = PH_EXT_HDR;
						n_skip  = '0;
					end else begin
						n_phase = PH_DONE;
					end
				end
			end
			PH_SNI_PREFIX: begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					n_phase = PH_SNI_NAME;
				end
			end
			PH_SNI_NAME: begin
				name_hit = 1'b1;
				n_nemit  = nemit_q + 8'd1;
				if (n_nemit >= target_q) begin
					n_done  = 1'b1;
					n_phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		rlen_need = {2'b00, n_rlen} + 18'd5;

		name_res             = '0;
		name_res.name_byte   = data_s1;
		name_res.name_index  = nemit_q;
		name_res.run_end     = !last_s1;

		verd_res            = '0;
		verd_res.is_verdict = 1'b1;
		verd_res.run_end    = 1'b1;
		if (count < 18'd5) begin
			verd_res.status = tse_pkg::ST_SHORT;
		end else if (n_done && rlen_need <= count) begin
			verd_res.status      = tse_pkg::ST_FOUND;
			verd_res.name_length = n_nemit;
		end else begin
			verd_res.status = tse_pkg::ST_NO_SNI;
		end

		push = '0;
		if (valid_s1) begin
			if (name_hit) begin
				push.res0 = name_res;
				push.res1 = verd_res;
				push.cnt  = last_s1 ? 2'd2 : 2'd1;
			end else if (last_s1) begin
				push.res0 = verd_res;
				push.cnt  = 2'd1;
			end
		end

		// end of payload: next byte starts a fresh record
		if (last_s1) begin
			n_pos    = '0;
			n_phase  = PH_CTYPE;
			n_skip   = '0;
			n_rlen   = '0;
			n_ee     = '0;
			n_etype  = '0;
			n_hold   = '0;
			n_target = '0;
			n_nemit  = '0;
			n_done   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= 9'd256;
			pos_q    <= '0;
			phase_q  <= PH_CTYPE;
			skip_q   <= '0;
			rlen_q   <= '0;
			ee_q     <= '0;
			etype_q  <= '0;
			hold_q   <= '0;
			target_q <= '0;
			nemit_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (valid_s1) begin
				pos_q    <= n_pos;
				phase_q  <= n_phase;
				skip_q   <= n_skip;
				rlen_q   <= n_rlen;
				ee_q     <= n_ee;
				etype_q  <= n_etype;
				hold_q   <= n_hold;
				target_q <= n_target;
				nemit_q  <= n_nemit;
				done_q   <= n_done;
			end
		end
	end

	`TSE_ASSERT(a_last_gives_verdict, clk, arst_n, (valid_s1 && last_s1) |-> (push.cnt != 2'd0))
	`TSE_ASSERT(a_pair_order, clk, arst_n, (push.cnt == 2'd2) |-> (!push.res0.is_verdict && push.res1.is_verdict))
	`TSE_ASSERT_NEXT(a_clear_after_last, clk, arst_n, valid_s1 && last_s1, phase_q == PH_CTYPE && pos_q == '0 && !done_q)

endmodule

// ===== src/tls_sni_extractor.sv =====
// A request's first result is registered in the input register, then written to the result queue, which offers it.
// Throughput: one byte per cycle; each byte yields zero, one or two results.
// Input stalls only when the eight-entry result queue holds more than four results.
// Reset (arst_n low, asynchronous): parse state and queue cleared, name_capacity = 256.
// The last byte of a payload also returns the parse state to its reset values.
`include "tls_sni_extractor_defines.svh"

module tls_sni_extractor #(
	parameter int MAX_NAME = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	tse_in_if.sink     byte_ch,
	tse_out_if.source  result_ch,
	input  logic       cfg_wr_en,
	input  logic [8:0] cfg_wr_data
);

	tse_pkg::push_t push;
	logic           space_ok;
	logic           accept;

	assign byte_ch.ready = space_ok;
	assign accept        = byte_ch.valid && space_ok;

	tse_parser #(
		.MAX_NAME(MAX_NAME)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_data    (byte_ch.data_byte),
		.in_last    (byte_ch.last_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push)
	);

	tse_res_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.space_ok(space_ok),
		.res     (result_ch)
	);

	`TSE_ASSERT_NEXT(a_accept_reaches_queue, clk, arst_n, accept && byte_ch.last_byte, push.cnt != 2'd0)

endmodule

// ===== tb/tls_sni_extractor_test.sv =====
module tls_sni_extractor_test;

	localparam int NAME_BUF = 256;
	localparam int REC_HDR_LEN = 5;
	localparam int HELLO_FIXED_END = 42;	// last byte of version + random
	localparam int SNI_PREFIX_LEN = 5;
	localparam logic [16:0] POS_SAT = 17'h1FFFF;
	localparam logic [7:0] CT_HANDSHAKE = 8'h16;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
	localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_BYTES = 250;
	localparam int MAX_REPORTS = 40;

	typedef enum logic [3:0] {
		AT_TYPE, AT_HEADER, AT_SID_LEN, AT_SID, AT_SUITES_HI, AT_SUITES_LO, AT_SUITES,
		AT_COMP_LEN, AT_COMP, AT_EXTS_HI, AT_EXTS_LO, AT_EXT_HDR, AT_EXT_BODY,
		AT_SNI_HDR, AT_SNI_NAME, AT_HALT
	} parse_at_e;

	typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_req_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [8:0] cfg_wr_data;

	tse_in_if  byte_ch();
	tse_out_if result_ch();

	tls_sni_extractor #(
		.MAX_NAME(NAME_BUF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser copy
	logic [8:0]  capacity = 9'd256;
	logic [16:0] hs_pos;
	parse_at_e   parse_at;
	logic [15:0] skip_left;
	logic [15:0] rec_len;
	logic [16:0] ext_left;
	logic [15:0] ext_kind;
	logic [15:0] ext_size;
	logic [7:0]  hi_byte;
	logic [7:0]  name_goal;
	logic [7:0]  name_cnt;
	logic        sni_complete;

	tse_pkg::res_t due_results[$];
	byte_req_t     byte_reqs[$];
	logic [7:0]    frame[$];
	logic [7:0]    ext_blk[$];

	int bytes_queued = 0;
	int bytes_taken = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int err_count = 0;
	idle_e idle_mode = IDLE_FULL;
	byte_req_t tx_req;
	tse_pkg::res_t seen_res;
	tse_pkg::res_t due_res;

	task automatic parse_clear();
		hs_pos = '0;
		parse_at = AT_TYPE;
		skip_left = '0;
		rec_len = '0;
		ext_left = '0;
		ext_kind = '0;
		ext_size = '0;
		hi_byte = '0;
		name_goal = '0;
		name_cnt = '0;
		sni_complete = 1'b0;
	endtask

	task automatic walk_next_ext();
		if (ext_left >= 17'd4) begin
			parse_at = AT_EXT_HDR;
			skip_left = '0;
		end else begin
			parse_at = AT_HALT;
		end
	endtask

	task automatic sni_parse_byte(input logic [7:0] b, input logic last);
		logic [16:0] pos;
		int eff_cap;
		int nl;
		int cnt;
		tse_pkg::res_t name_res;
		tse_pkg::res_t verdict_res;
		logic has_name;
		pos = hs_pos;
		name_res = '0;
		verdict_res = '0;
		has_name = 1'b0;
		case (parse_at)
		AT_TYPE: parse_at = (b == CT_HANDSHAKE) ? AT_HEADER : AT_HALT;
		AT_HEADER: begin
			if (pos == 17'd3)
				rec_len = {b, 8'h00};
			else if (pos == 17'd4)
				rec_len = rec_len | {8'h00, b};
			if (pos == 17'd5 && b != HS_CLIENT_HELLO)
				parse_at = AT_HALT;
			else if (pos >= HELLO_FIXED_END)
				parse_at = AT_SID_LEN;
		end
		AT_SID_LEN: begin
			skip_left = {8'h00, b};
			parse_at = (b == 8'h00) ? AT_SUITES_HI : AT_SID;
		end
		AT_SID: begin
			skip_left = skip_left - 16'd1;
			if (skip_left == 16'd0)
				parse_at = AT_SUITES_HI;
		end
		AT_SUITES_HI: begin
			hi_byte = b;
			parse_at = AT_SUITES_LO;
		end
		AT_SUITES_LO: begin
			skip_left = {hi_byte, b};
			parse_at = (skip_left == 16'd0) ? AT_COMP_LEN : AT_SUITES;
		end
		AT_SUITES: begin
			skip_left = skip_left - 16'd1;
			if (skip_left == 16'd0)
				parse_at = AT_COMP_LEN;
		end
		AT_COMP_LEN: begin
			skip_left = {8'h00, b};
			parse_at = (b == 8'h00) ? AT_EXTS_HI : AT_COMP;
		end
		AT_COMP: begin
			skip_left = skip_left - 16'd1;
			if (skip_left == 16'd0)
				parse_at = AT_EXTS_HI;
		end
		AT_EXTS_HI: begin
			hi_byte = b;
			parse_at = AT_EXTS_LO;
		end
		AT_EXTS_LO: begin
			ext_left = {1'b0, hi_byte, b};
			walk_next_ext();
		end
		AT_EXT_HDR: begin
			if (ext_left != 17'd0)
				ext_left = ext_left - 17'd1;
			case (skip_left)
			16'd0: begin
				ext_kind = {b, 8'h00};
				skip_left = 16'd1;
			end
			16'd1: begin
				ext_kind = ext_kind | {8'h00, b};
				skip_left = 16'd2;
			end
			16'd2: begin
				hi_byte = b;
				skip_left = 16'd3;
			end
			default: begin
				ext_size = {hi_byte, b};
				if (ext_kind == EXT_SERVER_NAME && ext_size > SNI_PREFIX_LEN) begin
					nl = int'(ext_size) - SNI_PREFIX_LEN;
					eff_cap = int'(capacity);
					if (eff_cap < 2)
						eff_cap = 2;
					if (eff_cap > NAME_BUF)
						eff_cap = NAME_BUF;
					name_goal = 8'((nl > eff_cap - 1) ? eff_cap - 1 : nl);
					skip_left = 16'(SNI_PREFIX_LEN);
					parse_at = AT_SNI_HDR;
				end else if (ext_size == 16'd0) begin
					walk_next_ext();
				end else begin
					skip_left = ext_size;
					parse_at = AT_EXT_BODY;
				end
			end
			endcase
		end
		AT_EXT_BODY: begin
			if (ext_left != 17'd0)
				ext_left = ext_left - 17'd1;
			skip_left = skip_left - 16'd1;
			if (skip_left == 16'd0)
				walk_next_ext();
		end
		AT_SNI_HDR: begin
			skip_left = skip_left - 16'd1;
			if (skip_left == 16'd0)
				parse_at = AT_SNI_NAME;
		end
		AT_SNI_NAME: begin
			name_res.name_byte = b;
			name_res.name_index = name_cnt;
			has_name = 1'b1;
			name_cnt = name_cnt + 8'd1;
			if (name_cnt >= name_goal) begin
				sni_complete = 1'b1;
				parse_at = AT_HALT;
			end
		end
		default: ;
		endcase

		if (pos != POS_SAT)
			hs_pos = pos + 17'd1;

		if (last) begin
			cnt = int'(pos) + 1;
			verdict_res.is_verdict = 1'b1;
			verdict_res.run_end = 1'b1;
			if (cnt < REC_HDR_LEN) begin
				verdict_res.status = tse_pkg::ST_SHORT;
			end else if (sni_complete && int'(rec_len) + REC_HDR_LEN <= cnt) begin
				verdict_res.status = tse_pkg::ST_FOUND;
				verdict_res.name_length = name_cnt;
			end else begin
				verdict_res.status = tse_pkg::ST_NO_SNI;
			end
			parse_clear();
		end else begin
			name_res.run_end = 1'b1;
		end
		if (has_name)
			due_results.push_back(name_res);
		if (last)
			due_results.push_back(verdict_res);
	endtask

	function automatic int pick_wait();
		case (idle_mode)
		IDLE_NONE: return 0;
		IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
		default: return $urandom_range(0, 19);
		endcase
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic string res_text(input tse_pkg::res_t r);
		return $sformatf("verdict=%0d byte=%02h index=%0d status=%0d length=%0d end=%0d",
			r.is_verdict, r.name_byte, r.name_index, r.status, r.name_length, r.run_end);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				sni_parse_byte(byte_ch.data_byte, byte_ch.last_byte);
				bytes_taken++;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (tx_wait != 0) begin
					tx_wait--;
					byte_ch.valid <= 1'b0;
				end else if (byte_reqs.size() != 0) begin
					tx_req = byte_reqs.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.data_byte <= tx_req.data;
					byte_ch.last_byte <= tx_req.last;
					tx_wait = pick_wait();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				seen_res.is_verdict = result_ch.is_verdict;
				seen_res.name_byte = result_ch.name_byte;
				seen_res.name_index = result_ch.name_index;
				seen_res.status = result_ch.status;
				seen_res.name_length = result_ch.name_length;
				seen_res.run_end = result_ch.run_end;
				if (due_results.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: result with none due: expected none, actual %s",
							$time, res_text(seen_res));
				end else begin
					due_res = due_results.pop_front();
					if (seen_res.is_verdict !== due_res.is_verdict ||
							seen_res.name_byte !== due_res.name_byte ||
							seen_res.name_index !== due_res.name_index ||
							seen_res.status !== due_res.status ||
							seen_res.name_length !== due_res.name_length ||
							seen_res.run_end !== due_res.run_end) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("%0t: mismatch: expected %s, actual %s", $time,
								res_text(due_res), res_text(seen_res));
					end
				end
				rx_wait = pick_wait();
			end
			if (rx_wait != 0) begin
				rx_wait--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic wait_results();
		while (bytes_taken != bytes_queued || due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [8:0] v);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		capacity = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_frame(input int keep);
		byte_req_t r;
		for (int i = 0; i < keep; i++) begin
			r.data = frame[i];
			r.last = (i == keep - 1);
			byte_reqs.push_back(r);
		end
		bytes_queued += keep;
	endtask

	task automatic start_hello(input logic [7:0] ctype, input logic [7:0] hstype);
		frame.delete();
		ext_blk.delete();
		frame.push_back(ctype);
		frame.push_back(8'h03);
		frame.push_back(8'h01);
		frame.push_back(8'h00);
		frame.push_back(8'h00);
		frame.push_back(hstype);
		repeat (HELLO_FIXED_END - 5) frame.push_back(rnd8());
	endtask

	task automatic add_lists(input int sess, input int suites, input int comp);
		logic [15:0] s16;
		s16 = 16'(suites);
		frame.push_back(sess[7:0]);
		repeat (sess) frame.push_back(rnd8());
		frame.push_back(s16[15:8]);
		frame.push_back(s16[7:0]);
		repeat (suites) frame.push_back(rnd8());
		frame.push_back(comp[7:0]);
		repeat (comp) frame.push_back(rnd8());
	endtask

	task automatic add_ext(input logic [15:0] kind, input int len);
		logic [15:0] l16;
		l16 = 16'(len);
		ext_blk.push_back(kind[15:8]);
		ext_blk.push_back(kind[7:0]);
		ext_blk.push_back(l16[15:8]);
		ext_blk.push_back(l16[7:0]);
		repeat (len) ext_blk.push_back(rnd8());
	endtask

	// server_name extension: list length, name type, name length, then the name
	task automatic add_sni(input int host_len);
		logic [15:0] l16;
		l16 = 16'(host_len + SNI_PREFIX_LEN);
		ext_blk.push_back(EXT_SERVER_NAME[15:8]);
		ext_blk.push_back(EXT_SERVER_NAME[7:0]);
		ext_blk.push_back(l16[15:8]);
		ext_blk.push_back(l16[7:0]);
		l16 = 16'(host_len + 3);
		ext_blk.push_back(l16[15:8]);
		ext_blk.push_back(l16[7:0]);
		ext_blk.push_back(8'h00);
		l16 = 16'(host_len);
		ext_blk.push_back(l16[15:8]);
		ext_blk.push_back(l16[7:0]);
		repeat (host_len) ext_blk.push_back(rnd8());
	endtask

	task automatic close_hello(input int ext_adj, input int rec_adj);
		logic [15:0] t16;
		t16 = 16'(int'(ext_blk.size()) + ext_adj);
		frame.push_back(t16[15:8]);
		frame.push_back(t16[7:0]);
		foreach (ext_blk[i]) frame.push_back(ext_blk[i]);
		t16 = 16'(int'(frame.size()) - REC_HDR_LEN + rec_adj);
		frame[3] = t16[15:8];
		frame[4] = t16[7:0];
	endtask

	task automatic sni_hello(input int host_len);
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists($urandom_range(0, 8), 2 * $urandom_range(1, 4), 1);
		add_sni(host_len);
		close_hello(0, 0);
		send_frame(frame.size());
	endtask

	task automatic add_random_ext();
		if ($urandom_range(0, 3) == 0)
			add_ext(EXT_SERVER_NAME, $urandom_range(0, SNI_PREFIX_LEN));
		else
			add_ext(16'($urandom_range(0, 65535)), $urandom_range(0, 12));
	endtask

	task automatic random_hello();
		int k;
		int ext_adj;
		int rec_adj;
		logic [7:0] ct;
		logic [7:0] ht;
		ct = ($urandom_range(0, 19) == 0) ? rnd8() : CT_HANDSHAKE;
		ht = ($urandom_range(0, 19) == 0) ? rnd8() : HS_CLIENT_HELLO;
		start_hello(ct, ht);
		add_lists(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32),
			($urandom_range(0, 7) == 0) ? 0 : 2 * $urandom_range(1, 20),
			($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
		repeat ($urandom_range(0, 3)) add_random_ext();
		if ($urandom_range(0, 9) != 0)
			add_sni(($urandom_range(0, 9) == 0) ? $urandom_range(200, 300)
				: $urandom_range(1, 24));
		repeat ($urandom_range(0, 2)) add_random_ext();
		k = $urandom_range(0, 8);
		ext_adj = ($urandom_range(0, 7) == 0) ? k - 4 : 0;
		k = $urandom_range(0, 6);
		rec_adj = ($urandom_range(0, 7) == 0) ? k - 3 : 0;
		close_hello(ext_adj, rec_adj);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 8)) frame.push_back(rnd8());
		if ($urandom_range(0, 9) == 0)
			send_frame($urandom_range(1, frame.size()));
		else
			send_frame(frame.size());
	endtask

	initial begin
		#30_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int rand_start;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		parse_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short payloads
		frame.delete();
		frame.push_back(CT_HANDSHAKE);
		send_frame(1);
		frame.delete();
		repeat (4) frame.push_back(rnd8());
		send_frame(4);
		frame.delete();
		frame.push_back(CT_HANDSHAKE);
		frame.push_back(8'h03);
		frame.push_back(8'h01);
		frame.push_back(8'h00);
		frame.push_back(8'h00);
		send_frame(5);

		// smallest well-formed hello, then one with every list present
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(0, 0, 0);
		add_sni(1);
		close_hello(0, 0);
		send_frame(frame.size());
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(32, 2, 3);
		add_sni(10);
		close_hello(0, 0);
		send_frame(frame.size());

		// wrong record type and wrong handshake type
		start_hello(8'h17, HS_CLIENT_HELLO);
		add_lists(0, 2, 1);
		add_sni(6);
		close_hello(0, 0);
		send_frame(frame.size());
		start_hello(CT_HANDSHAKE, 8'h02);
		add_lists(0, 2, 1);
		add_sni(6);
		close_hello(0, 0);
		send_frame(frame.size());

		// server_name too short to count, empty and other extensions before the real one
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(1, 4, 1);
		add_ext(EXT_SERVER_NAME, SNI_PREFIX_LEN);
		add_ext(16'hFFFF, 0);
		add_ext(16'h000A, 4);
		add_sni(8);
		close_hello(0, 0);
		send_frame(frame.size());

		// extension block ends with 3 bytes left, with 4 left, and mid-body
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(0, 2, 1);
		add_ext(16'h0017, 2);
		add_sni(6);
		close_hello(-12, 0);
		send_frame(frame.size());
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(0, 2, 1);
		add_ext(16'h0017, 2);
		add_sni(6);
		close_hello(-11, 0);
		send_frame(frame.size());
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(0, 2, 1);
		add_ext(16'h0023, 10);
		add_sni(4);
		close_hello(-19, 0);
		send_frame(frame.size());

		// cut mid-name, record length around payload size
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(0, 2, 1);
		add_sni(20);
		close_hello(0, 0);
		send_frame(frame.size() - 5);
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(64, 2, 1);
		add_sni(12);
		close_hello(0, 1);
		send_frame(frame.size());
		start_hello(CT_HANDSHAKE, HS_CLIENT_HELLO);
		add_lists(3, 2, 1);
		add_sni(12);
		close_hello(0, -1);
		send_frame(frame.size());

		// buffer size, extremes and out-of-range values
		idle_mode = IDLE_SOME;
		set_capacity(9'd2);
		sni_hello(1);
		sni_hello(5);
		set_capacity(9'd0);
		sni_hello(3);
		set_capacity(9'd1);
		sni_hello(3);
		set_capacity(9'd511);
		sni_hello(260);
		set_capacity(9'd257);
		sni_hello(3);
		set_capacity(9'd3);
		sni_hello(2);
		sni_hello(2);

		// back-to-back bytes with no idling on either side
		idle_mode = IDLE_NONE;
		set_capacity(9'd256);
		sni_hello(40);

		rand_start = bytes_queued;
		while (bytes_queued - rand_start < RANDOM_BYTES) begin
			case ($urandom_range(0, 5))
			0: set_capacity(9'd2);
			1: set_capacity(9'd256);
			2: set_capacity(9'($urandom_range(0, 1)));
			3: set_capacity(9'($urandom_range(257, 511)));
			default: set_capacity(9'($urandom_range(3, 40)));
			endcase
			idle_mode = idle_e'($urandom_range(0, 2));
			repeat (4) begin
				if ($urandom_range(0, 4) == 0) begin
					frame.delete();
					repeat ($urandom_range(1, 8)) frame.push_back(rnd8());
					if ($urandom_range(0, 1) == 1)
						frame[0] = CT_HANDSHAKE;
					send_frame(frame.size());
				end else begin
					random_hello();
				end
			end
			if ($urandom_range(0, 3) == 0)
				wait_results();
		end

		wait_results();
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (err_count == 0 && due_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== tls_sni_extractor.f =====
+incdir+src
src/tse_pkg.sv
src/tse_if.sv
src/tse_res_fifo.sv
src/tse_parser.sv
src/tls_sni_extractor.sv
tb/tls_sni_extractor_test.sv
